FILE: sv/c2d_pkg.sv
// Shared types and constants for the multi-channel 2D convolution engine.
package c2d_pkg;

    localparam int CMD_W      = 2;
    localparam int ICH_W      = 2;
    localparam int OCH_W      = 3;
    localparam int POS_W      = 6;
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 48;
    localparam int PAD_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_PIX = 2'd0,
        CMD_LOAD_WGT = 2'd1,
        CMD_COMPUTE  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL   = 3'd0,
        CFG_STRIDE   = 3'd1,
        CFG_IN_CH    = 3'd2,
        CFG_OUT_CH   = 3'd3,
        CFG_HEIGHT   = 3'd4,
        CFG_WIDTH    = 3'd5,
        CFG_SAME_PAD = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Effective (clamped) configuration plus derived padding.
    typedef struct packed {
        logic [2:0]       kernel;
        logic [2:0]       stride;
        logic [2:0]       in_ch;
        logic [3:0]       out_ch;
        logic [6:0]       height;
        logic [6:0]       width;
        logic [PAD_W-1:0] pad_h;
        logic [PAD_W-1:0] pad_w;
    } t_cfg_eff;

    typedef struct packed {
        logic img_we;
        logic wgt_we;
        logic rd_en;
    } t_mem_ctl;

endpackage

FILE: sv/c2d_cfg.sv
// Configuration register file with range clamping and same-mode padding.
module c2d_cfg import c2d_pkg::*; #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_IN_CH  = 4,
    parameter int MAX_OUT_CH = 8,
    parameter int MAX_KERNEL = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg_eff              o_eff
);

    localparam int K_LIM  = (MAX_KERNEL < 7)  ? MAX_KERNEL : 7;
    localparam int IC_LIM = (MAX_IN_CH < 4)   ? MAX_IN_CH  : 4;
    localparam int OC_LIM = (MAX_OUT_CH < 8)  ? MAX_OUT_CH : 8;
    localparam int H_LIM  = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
    localparam int W_LIM  = (MAX_WIDTH < 64)  ? MAX_WIDTH  : 64;

    logic [2:0] r_kernel;
    logic [2:0] r_stride;
    logic [2:0] r_in_ch;
    logic [3:0] r_out_ch;
    logic [6:0] r_height;
    logic [6:0] r_width;
    logic       r_same;

    logic [9:0] span_h;
    logic [9:0] span_w;

    function automatic logic [7:0] clamp_u(input logic [7:0] v, input logic [7:0] lim);
        logic [7:0] res;
        if (v == 8'd0) begin
            res = 8'd1;
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= 3'd3;
            r_stride <= 3'd1;
            r_in_ch  <= 3'd1;
            r_out_ch <= 4'd1;
            r_height <= 7'd64;
            r_width  <= 7'd64;
            r_same   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KERNEL:   r_kernel <= i_cfg_data[2:0];
                CFG_STRIDE:   r_stride <= i_cfg_data[2:0];
                CFG_IN_CH:    r_in_ch  <= i_cfg_data[2:0];
                CFG_OUT_CH:   r_out_ch <= i_cfg_data[3:0];
                CFG_HEIGHT:   r_height <= i_cfg_data[6:0];
                CFG_WIDTH:    r_width  <= i_cfg_data[6:0];
                CFG_SAME_PAD: r_same   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_eff.kernel = 3'(clamp_u(8'(r_kernel), 8'(K_LIM)));
        o_eff.stride = 3'(clamp_u(8'(r_stride), 8'd4));
        o_eff.in_ch  = 3'(clamp_u(8'(r_in_ch), 8'(IC_LIM)));
        o_eff.out_ch = 4'(clamp_u(8'(r_out_ch), 8'(OC_LIM)));
        o_eff.height = 7'(clamp_u(8'(r_height), 8'(H_LIM)));
        o_eff.width  = 7'(clamp_u(8'(r_width), 8'(W_LIM)));
        // pad = (k + (s-1)*n - s) / 2, never negative since k >= 1
        span_h = 10'(o_eff.kernel) + (10'(o_eff.stride) - 10'd1) * 10'(o_eff.height)
                 - 10'(o_eff.stride);
        span_w = 10'(o_eff.kernel) + (10'(o_eff.stride) - 10'd1) * 10'(o_eff.width)
                 - 10'(o_eff.stride);
        o_eff.pad_h = r_same ? PAD_W'(span_h >> 1) : '0;
        o_eff.pad_w = r_same ? PAD_W'(span_w >> 1) : '0;
    end

endmodule

FILE: sv/c2d_mem.sv
// Image and weight stores, single port each, registered read data.
module c2d_mem import c2d_pkg::*; #(
    parameter int IMG_DEPTH = 16384,
    parameter int IMG_AW    = 14,
    parameter int WGT_DEPTH = 1568,
    parameter int WGT_AW    = 11
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [IMG_AW-1:0] i_img_addr,
    input  logic [WGT_AW-1:0] i_wgt_addr,
    input  logic [VAL_W-1:0]  i_wdata,
    output logic [VAL_W-1:0]  o_img_rdata,
    output logic [VAL_W-1:0]  o_wgt_rdata
);

    logic [VAL_W-1:0] r_img_mem [IMG_DEPTH];
    logic [VAL_W-1:0] r_wgt_mem [WGT_DEPTH];
    logic [VAL_W-1:0] r_img_rdata;
    logic [VAL_W-1:0] r_wgt_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.img_we) begin
            r_img_mem[i_img_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_img_rdata <= r_img_mem[i_img_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wgt_we) begin
            r_wgt_mem[i_wgt_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_wgt_rdata <= r_wgt_mem[i_wgt_addr];
        end
    end

    assign o_img_rdata = r_img_rdata;
    assign o_wgt_rdata = r_wgt_rdata;

endmodule

FILE: sv/c2d_ctrl.sv
// Command sequencer: load decode, tap walk, multiply-accumulate and result register.
module c2d_ctrl import c2d_pkg::*; #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_OUT_CH = 8,
    parameter int MAX_KERNEL = 7,
    parameter int IMG_AW     = 14,
    parameter int WGT_AW     = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [ICH_W-1:0]        i_in_chan,
    input  logic [OCH_W-1:0]        i_out_chan,
    input  logic [POS_W-1:0]        i_row,
    input  logic [POS_W-1:0]        i_col,
    input  logic [VAL_W-1:0]        i_value,
    input  t_cfg_eff                i_eff,
    output t_mem_ctl                o_mem,
    output logic [IMG_AW-1:0]       o_img_addr,
    output logic [WGT_AW-1:0]       o_wgt_addr,
    output logic [VAL_W-1:0]        o_wdata,
    input  logic [VAL_W-1:0]        i_img_rdata,
    input  logic [VAL_W-1:0]        i_wgt_rdata,
    output logic                    o_valid,
    output logic                    o_status,
    output logic signed [SUM_W-1:0] o_sum
);

    t_state r_state, n_state;

    // request
    logic [CMD_W-1:0] r_cmd;
    logic [ICH_W-1:0] r_ich;
    logic [OCH_W-1:0] r_och;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic [VAL_W-1:0] r_value;

    // tap walk
    logic signed [10:0] r_r0, n_r0;
    logic signed [10:0] r_c0, n_c0;
    logic [ICH_W-1:0]   r_ch, n_ch;
    logic [2:0]         r_kr, n_kr;
    logic [2:0]         r_kc, n_kc;

    // MAC pipe
    logic                     r_p1, n_p1;
    logic                     r_p2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc, n_acc;

    // result
    logic                    r_valid, n_valid;
    logic                    r_status, n_status;
    logic signed [SUM_W-1:0] r_sum, n_sum;

    logic               pix_ok, wgt_ok, comp_ok;
    logic [8:0]         rs, cs;
    logic signed [10:0] y, x;
    logic               tap_in, last_tap;
    logic [IMG_AW-1:0]  pix_addr, tap_img_addr;
    logic [WGT_AW-1:0]  wgt_addr, tap_wgt_addr;

    always_comb begin
        pix_ok = (3'(r_ich) < i_eff.in_ch) && (7'(r_row) < i_eff.height)
                 && (7'(r_col) < i_eff.width);
        wgt_ok = (3'(r_ich) < i_eff.in_ch) && (4'(r_och) < i_eff.out_ch)
                 && (r_row < 6'(i_eff.kernel)) && (r_col < 6'(i_eff.kernel));
        rs = 9'(r_row) * 9'(i_eff.stride);
        cs = 9'(r_col) * 9'(i_eff.stride);
        // output position valid when pos*s + k fits in the padded span
        comp_ok = (4'(r_och) < i_eff.out_ch)
                  && (11'(rs) + 11'(i_eff.kernel)
                      <= 11'(i_eff.height) + 11'({i_eff.pad_h, 1'b0}))
                  && (11'(cs) + 11'(i_eff.kernel)
                      <= 11'(i_eff.width) + 11'({i_eff.pad_w, 1'b0}));

        y = r_r0 + $signed(11'(r_kr));
        x = r_c0 + $signed(11'(r_kc));
        tap_in = !y[10] && !x[10] && (y[9:0] < 10'(i_eff.height))
                 && (x[9:0] < 10'(i_eff.width));
        last_tap = (3'(r_ch) == i_eff.in_ch - 3'd1) && (r_kr == i_eff.kernel - 3'd1)
                   && (r_kc == i_eff.kernel - 3'd1);

        pix_addr = IMG_AW'((r_ich * MAX_HEIGHT + r_row) * MAX_WIDTH + r_col);
        wgt_addr = WGT_AW'(((r_ich * MAX_OUT_CH + r_och) * MAX_KERNEL + r_row)
                           * MAX_KERNEL + r_col);
        tap_img_addr = IMG_AW'((r_ch * MAX_HEIGHT + y[5:0]) * MAX_WIDTH + x[5:0]);
        tap_wgt_addr = WGT_AW'(((r_ch * MAX_OUT_CH + r_och) * MAX_KERNEL + r_kr)
                               * MAX_KERNEL + r_kc);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if ((r_cmd == CMD_COMPUTE) && comp_ok) begin
                    n_state = ST_RUN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1 && !r_p2) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_mem      = '0;
        o_img_addr = tap_img_addr;
        o_wgt_addr = tap_wgt_addr;
        o_wdata    = r_value;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_sum      = r_sum;
        n_r0       = r_r0;
        n_c0       = r_c0;
        n_ch       = r_ch;
        n_kr       = r_kr;
        n_kc       = r_kc;
        n_p1       = 1'b0;
        n_acc      = r_p2 ? r_acc + SUM_W'(r_prod) : r_acc;
        case (r_state)
            ST_DECODE: begin
                n_r0  = $signed(11'(rs)) - $signed(11'(i_eff.pad_h));
                n_c0  = $signed(11'(cs)) - $signed(11'(i_eff.pad_w));
                n_ch  = '0;
                n_kr  = '0;
                n_kc  = '0;
                n_acc = '0;
                case (r_cmd)
                    CMD_LOAD_PIX: begin
                        o_mem.img_we = pix_ok;
                        o_img_addr   = pix_addr;
                        n_valid      = 1'b1;
                        n_status     = !pix_ok;
                        n_sum        = '0;
                    end
                    CMD_LOAD_WGT: begin
                        o_mem.wgt_we = wgt_ok;
                        o_wgt_addr   = wgt_addr;
                        n_valid      = 1'b1;
                        n_status     = !wgt_ok;
                        n_sum        = '0;
                    end
                    CMD_COMPUTE: begin
                        if (!comp_ok) begin
                            n_valid  = 1'b1;
                            n_status = 1'b1;
                            n_sum    = '0;
                        end
                    end
                    default: begin
                        n_valid  = 1'b1;
                        n_status = 1'b1;
                        n_sum    = '0;
                    end
                endcase
            end
            ST_RUN: begin
                // taps outside the image are skipped, adding zero
                o_mem.rd_en = tap_in;
                n_p1        = tap_in;
                if (r_kc == i_eff.kernel - 3'd1) begin
                    n_kc = '0;
                    if (r_kr == i_eff.kernel - 3'd1) begin
                        n_kr = '0;
                        n_ch = r_ch + 1'b1;
                    end else begin
                        n_kr = r_kr + 3'd1;
                    end
                end else begin
                    n_kc = r_kc + 3'd1;
                end
            end
            ST_DRAIN: begin
                if (!r_p1 && !r_p2) begin
                    n_valid  = 1'b1;
                    n_status = 1'b0;
                    n_sum    = r_acc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1    <= n_p1;
            r_p2    <= r_p1;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start) begin
            r_cmd   <= i_cmd;
            r_ich   <= i_in_chan;
            r_och   <= i_out_chan;
            r_row   <= i_row;
            r_col   <= i_col;
            r_value <= i_value;
        end
        r_r0     <= n_r0;
        r_c0     <= n_c0;
        r_ch     <= n_ch;
        r_kr     <= n_kr;
        r_kc     <= n_kc;
        r_prod   <= $signed(i_img_rdata) * $signed(i_wgt_rdata);
        r_acc    <= n_acc;
        r_status <= n_status;
        r_sum    <= n_sum;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_sum    = r_sum;

endmodule

FILE: sv/conv2d_multichannel_forward_top.sv
// Top level: multi-channel zero-padded strided 2D convolution, one output pixel per command.
// Loads: write in the decode state, result strobe registered; next start taken back in idle.
// Compute: walks in_channels * kside^2 taps through the store read port, one tap per
//   cycle, then drains the read and product registers before the result strobe.
// Bad index or unknown command: status 1, set in decode. The result strobe lasts one cycle.
// Reset (sync, active low) restores the register defaults; the stores keep no reset state.
module conv2d_multichannel_forward_top import c2d_pkg::*; #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_IN_CH  = 4,
    parameter int MAX_OUT_CH = 8,
    parameter int MAX_KERNEL = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command request
    input  logic                    start,
    output logic                    busy,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [ICH_W-1:0]        i_in_chan,
    input  logic [OCH_W-1:0]        i_out_chan,
    input  logic [POS_W-1:0]        i_row,
    input  logic [POS_W-1:0]        i_col,
    input  logic signed [VAL_W-1:0] i_value,
    // result
    output logic                    o_valid,
    output logic                    o_status,
    output logic signed [SUM_W-1:0] o_sum,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // Image store: channel x row x col. Weight store: in ch x out ch x krow x kcol.
    localparam int IMG_DEPTH = MAX_IN_CH * MAX_HEIGHT * MAX_WIDTH;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int WGT_DEPTH = MAX_IN_CH * MAX_OUT_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

    t_cfg_eff          eff;
    t_mem_ctl          mem_ctl;
    logic [IMG_AW-1:0] img_addr;
    logic [WGT_AW-1:0] wgt_addr;
    logic [VAL_W-1:0]  wdata;
    logic [VAL_W-1:0]  img_rdata;
    logic [VAL_W-1:0]  wgt_rdata;

    // Clamped registers and same-mode padding
    c2d_cfg #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_eff       (eff)
    );

    // Pixel and weight stores, registered read data
    c2d_mem #(
        .IMG_DEPTH (IMG_DEPTH),
        .IMG_AW    (IMG_AW),
        .WGT_DEPTH (WGT_DEPTH),
        .WGT_AW    (WGT_AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_img_addr  (img_addr),
        .i_wgt_addr  (wgt_addr),
        .i_wdata     (wdata),
        .o_img_rdata (img_rdata),
        .o_wgt_rdata (wgt_rdata)
    );

    // Sequencer and MAC; one request in flight at a time
    c2d_ctrl #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_KERNEL (MAX_KERNEL),
        .IMG_AW     (IMG_AW),
        .WGT_AW     (WGT_AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (i_cmd),
        .i_in_chan   (i_in_chan),
        .i_out_chan  (i_out_chan),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_eff       (eff),
        .o_mem       (mem_ctl),
        .o_img_addr  (img_addr),
        .o_wgt_addr  (wgt_addr),
        .o_wdata     (wdata),
        .i_img_rdata (img_rdata),
        .i_wgt_rdata (wgt_rdata),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_sum       (o_sum)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-channel 2D convolution engine top level.
module tb_top;
    import c2d_pkg::*;

    // Store geometry of the default build (the instance below keeps the defaults).
    localparam int IMG_ROWS  = 64;
    localparam int IMG_COLS  = 64;
    localparam int CH_MAX    = 4;
    localparam int OCH_MAX   = 8;
    localparam int K_MAX     = 7;
    localparam int PIX_DEPTH = CH_MAX * IMG_ROWS * IMG_COLS;
    localparam int WGT_DEPTH = CH_MAX * OCH_MAX * K_MAX * K_MAX;

    // Opcode the block does not decode: must come back as an error status.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 100;
    localparam int SETTLE_TICKS = 8;    // idle gap before a register write
    localparam int TAIL_TICKS   = 250;  // longer than the slowest compute

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the registers and both stores, predicts the
    // status and sum of every accepted request, checks results in order.
    // ------------------------------------------------------------------
    class conv_pixel_checker;
        int kernel_raw, stride_raw, in_ch_raw, out_ch_raw;
        int height_raw, width_raw, same_raw;
        // effective (clamped) shape and derived padding / output size
        int k, s, ic, oc, h, w, pad_h, pad_w, out_rows, out_cols;

        shortint pix_mem [PIX_DEPTH];
        bit      pix_ok  [PIX_DEPTH];
        shortint wgt_mem [WGT_DEPTH];
        bit      wgt_ok  [WGT_DEPTH];

        bit     pending_status [$];
        longint pending_sum    [$];

        int errors, requests, convs, bad_status, reg_writes;

        function new();
            kernel_raw = 3;
            stride_raw = 1;
            in_ch_raw  = 1;
            out_ch_raw = 1;
            height_raw = 64;
            width_raw  = 64;
            same_raw   = 0;
            derive_shape();
        endfunction

        function int bound(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int out_len(int n, int pad);
            int span;
            span = n + 2 * pad;
            if (span < k) return 0;
            return (span - k) / s + 1;
        endfunction

        function void derive_shape();
            k  = bound(kernel_raw, 1, K_MAX);
            s  = bound(stride_raw, 1, 4);
            ic = bound(in_ch_raw, 1, CH_MAX);
            oc = bound(out_ch_raw, 1, OCH_MAX);
            h  = bound(height_raw, 1, IMG_ROWS);
            w  = bound(width_raw, 1, IMG_COLS);
            pad_h = 0;
            pad_w = 0;
            if (same_raw != 0) begin
                pad_h = (k + (s - 1) * h - s) / 2;
                pad_w = (k + (s - 1) * w - s) / 2;
            end
            out_rows = out_len(h, pad_h);
            out_cols = out_len(w, pad_w);
        endfunction

        function int pix_addr(int ch, int y, int x);
            return (ch * IMG_ROWS + y) * IMG_COLS + x;
        endfunction

        function int wgt_addr(int ch, int och, int kr, int kc);
            return ((ch * OCH_MAX + och) * K_MAX + kr) * K_MAX + kc;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_KERNEL:   kernel_raw = data[2:0];
                CFG_STRIDE:   stride_raw = data[2:0];
                CFG_IN_CH:    in_ch_raw  = data[2:0];
                CFG_OUT_CH:   out_ch_raw = data[3:0];
                CFG_HEIGHT:   height_raw = data;
                CFG_WIDTH:    width_raw  = data;
                CFG_SAME_PAD: same_raw   = data[0];
                default: ;
            endcase
            derive_shape();
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [ICH_W-1:0] ich_v,
                                   logic [OCH_W-1:0] och_v, logic [POS_W-1:0] r_v,
                                   logic [POS_W-1:0] c_v, logic [VAL_W-1:0] value);
            int ich, och, r, c, y, x, ch, kr, kc;
            bit st;
            longint acc;
            ich = ich_v;
            och = och_v;
            r   = r_v;
            c   = c_v;
            st  = 1'b1;
            acc = 0;
            requests++;
            case (cmd)
                CMD_LOAD_PIX: begin
                    if (ich < ic && r < h && c < w) begin
                        pix_mem[pix_addr(ich, r, c)] = shortint'(value);
                        pix_ok[pix_addr(ich, r, c)]  = 1'b1;
                        st = 1'b0;
                    end
                end
                CMD_LOAD_WGT: begin
                    if (ich < ic && och < oc && r < k && c < k) begin
                        wgt_mem[wgt_addr(ich, och, r, c)] = shortint'(value);
                        wgt_ok[wgt_addr(ich, och, r, c)]  = 1'b1;
                        st = 1'b0;
                    end
                end
                CMD_COMPUTE: begin
                    if (och < oc && r < out_rows && c < out_cols) begin
                        // taps falling in the padding contribute nothing
                        for (ch = 0; ch < ic; ch++)
                            for (kr = 0; kr < k; kr++)
                                for (kc = 0; kc < k; kc++) begin
                                    y = r * s - pad_h + kr;
                                    x = c * s - pad_w + kc;
                                    if (y >= 0 && y < h && x >= 0 && x < w)
                                        acc += longint'(pix_mem[pix_addr(ch, y, x)]) *
                                               longint'(wgt_mem[wgt_addr(ch, och, kr, kc)]);
                                end
                        st = 1'b0;
                        convs++;
                    end
                end
                default: ;
            endcase
            if (st) bad_status++;
            pending_status.push_back(st);
            pending_sum.push_back(acc);
        endfunction

        function void check_result(logic st, logic [SUM_W-1:0] sum);
            bit exp_st;
            longint exp_acc;
            logic [SUM_W-1:0] exp_bits;
            if (pending_sum.size() == 0) begin
                $display("%0t: result with no request outstanding: status %0b sum %0d",
                         $time, st, $signed(sum));
                errors++;
                return;
            end
            exp_st   = pending_status.pop_front();
            exp_acc  = pending_sum.pop_front();
            exp_bits = exp_acc[SUM_W-1:0];
            if (st !== exp_st) begin
                $display("%0t: status mismatch: expected %0b actual %0b", $time, exp_st, st);
                errors++;
            end
            if (sum !== exp_bits) begin
                $display("%0t: sum mismatch: expected %0d actual %0d",
                         $time, exp_acc, $signed(sum));
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        i_cmd;
    logic [ICH_W-1:0]        i_in_chan;
    logic [OCH_W-1:0]        i_out_chan;
    logic [POS_W-1:0]        i_row;
    logic [POS_W-1:0]        i_col;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_valid;
    logic                    o_status;
    logic signed [SUM_W-1:0] o_sum;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    conv_pixel_checker sb;
    bit steady;     // set for one phase: the sender never idles
    int sent;       // accepted requests so far

    conv2d_multichannel_forward_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_in_chan   (i_in_chan),
        .i_out_chan  (i_out_chan),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_sum       (o_sum),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock; first rising edge at 1 ns
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Monitor: everything is sampled at the rising edge. The result of an
    // older request is checked before a request taken on the same edge is
    // noted, so the FIFO order always matches the block's.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1)
                sb.check_result(o_status, o_sum);
            if (start === 1'b1 && busy === 1'b0)
                sb.note_request(i_cmd, i_in_chan, i_out_chan, i_row, i_col, i_value);
            if (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)
                sb.note_config(i_cfg_index, i_cfg_data);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers. All tasks are entered and left at a falling edge; inputs
    // change only there.
    // ------------------------------------------------------------------

    // Present one request and hold it until the block takes it. Start is
    // left high on return so back-to-back requests never glitch it.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [ICH_W-1:0] ich,
                                logic [OCH_W-1:0] och, logic [POS_W-1:0] r,
                                logic [POS_W-1:0] c, logic [VAL_W-1:0] value);
        int gap;
        gap = 0;
        if (!steady) begin
            // mostly short random gaps, now and then a long one
            if ($urandom_range(0, 49) == 0)
                gap = $urandom_range(8, 40);
            else
                while ($urandom_range(0, 99) < 36) gap++;
        end
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      = 1'b1;
        i_cmd      = cmd;
        i_in_chan  = ich;
        i_out_chan = och;
        i_row      = r;
        i_col      = c;
        i_value    = value;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
        sent++;
    endtask

    // Stop sending and wait for every outstanding result, then let the
    // block settle before anything else touches it.
    task automatic drain();
        start = 1'b0;
        while (sb.pending_sum.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    // One register write; valid is lowered by the caller after the group.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic write_shape(int kv, int sv, int icv, int ocv, int hv, int wv, int pv);
        write_reg(CFG_KERNEL, kv);
        write_reg(CFG_STRIDE, sv);
        write_reg(CFG_IN_CH, icv);
        write_reg(CFG_OUT_CH, ocv);
        write_reg(CFG_HEIGHT, hv);
        write_reg(CFG_WIDTH, wv);
        write_reg(CFG_SAME_PAD, pv);
        i_cfg_valid = 1'b0;
    endtask

    // Compute one output pixel. For an in-range position every store entry
    // the window can touch is loaded first, so no unwritten entry is ever
    // read. Weights are loaded for all taps, padding taps included.
    task automatic convolve_at(int och, int r, int c);
        int ch, kr, kc, y, x;
        if (och < sb.oc && r < sb.out_rows && c < sb.out_cols) begin
            for (ch = 0; ch < sb.ic; ch++)
                for (kr = 0; kr < sb.k; kr++)
                    for (kc = 0; kc < sb.k; kc++) begin
                        if (!sb.wgt_ok[sb.wgt_addr(ch, och, kr, kc)])
                            send_request(CMD_LOAD_WGT, ch, och, kr, kc,
                                         $urandom_range(0, 65535));
                        y = r * sb.s - sb.pad_h + kr;
                        x = c * sb.s - sb.pad_w + kc;
                        if (y >= 0 && y < sb.h && x >= 0 && x < sb.w &&
                            !sb.pix_ok[sb.pix_addr(ch, y, x)])
                            send_request(CMD_LOAD_PIX, ch, $urandom_range(0, 7), y, x,
                                         $urandom_range(0, 65535));
                    end
        end
        send_request(CMD_COMPUTE, $urandom_range(0, 3), och, r, c, $urandom_range(0, 65535));
    endtask

    // Random traffic under the current shape. Computes cluster around a
    // focus window so the loads they need are shared between them.
    task automatic random_phase(int budget);
        int stop, pick, fr, fc, fo, och, r, c;
        stop = sent + budget;
        fr = (sb.out_rows > 0) ? $urandom_range(0, sb.out_rows - 1) : 0;
        fc = (sb.out_cols > 0) ? $urandom_range(0, sb.out_cols - 1) : 0;
        fo = $urandom_range(0, sb.oc - 1);
        while (sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                if ($urandom_range(0, 99) < 85)
                    send_request(CMD_LOAD_PIX, $urandom_range(0, sb.ic - 1),
                                 $urandom_range(0, 7), $urandom_range(0, sb.h - 1),
                                 $urandom_range(0, sb.w - 1), $urandom_range(0, 65535));
                else
                    send_request(CMD_LOAD_PIX, $urandom_range(0, 3), $urandom_range(0, 7),
                                 $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 65535));
            end else if (pick < 50) begin
                if ($urandom_range(0, 99) < 85)
                    send_request(CMD_LOAD_WGT, $urandom_range(0, sb.ic - 1),
                                 $urandom_range(0, sb.oc - 1), $urandom_range(0, sb.k - 1),
                                 $urandom_range(0, sb.k - 1), $urandom_range(0, 65535));
                else
                    send_request(CMD_LOAD_WGT, $urandom_range(0, 3), $urandom_range(0, 7),
                                 $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 65535));
            end else if (pick < 95) begin
                och = $urandom_range(0, 7);
                r   = $urandom_range(0, 63);
                c   = $urandom_range(0, 63);
                // mostly well-formed: an in-range pick is pulled into the focus
                if ($urandom_range(0, 99) < 80 ||
                    (och < sb.oc && r < sb.out_rows && c < sb.out_cols)) begin
                    och = fo + $urandom_range(0, 1);
                    r   = fr + $urandom_range(0, 1);
                    c   = fc + $urandom_range(0, 1);
                    if (och >= sb.oc) och = fo;
                    if (r >= sb.out_rows) r = fr;
                    if (c >= sb.out_cols) c = fc;
                end
                convolve_at(och, r, c);
            end else begin
                send_request(CMD_UNKNOWN, $urandom_range(0, 3), $urandom_range(0, 7),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 65535));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        sb          = new();
        steady      = 1'b0;
        sent        = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = CMD_LOAD_PIX;
        i_in_chan   = '0;
        i_out_chan  = '0;
        i_row       = '0;
        i_col       = '0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_KERNEL;
        i_cfg_data  = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part on a 1x1 kernel, other registers at their defaults
        // (one channel each way, 64x64 image, valid mode).
        write_reg(CFG_KERNEL, 1);
        i_cfg_valid = 1'b0;
        send_request(CMD_LOAD_PIX, 0, 7, 0, 0, 16'h8000);
        send_request(CMD_LOAD_PIX, 0, 0, 63, 63, 16'h7fff);
        send_request(CMD_LOAD_PIX, 3, 0, 5, 5, 16'h1234);       // channel not in use
        send_request(CMD_LOAD_WGT, 0, 0, 0, 0, 16'h8000);
        send_request(CMD_LOAD_WGT, 1, 0, 0, 0, 16'h0000);       // input channel too big
        send_request(CMD_LOAD_WGT, 0, 7, 0, 0, 16'h0000);       // output channel too big
        send_request(CMD_LOAD_WGT, 0, 0, 0, 1, 16'hffff);       // tap outside kernel
        send_request(CMD_UNKNOWN, 3, 7, 63, 63, 16'hffff);
        send_request(CMD_COMPUTE, 0, 0, 0, 0, 16'h0000);        // most negative squared
        send_request(CMD_COMPUTE, 3, 0, 63, 63, 16'hffff);      // far corner
        send_request(CMD_COMPUTE, 0, 7, 0, 0, 16'h0000);        // output channel too big
        send_request(CMD_LOAD_WGT, 0, 0, 0, 0, 16'h7fff);
        send_request(CMD_COMPUTE, 0, 0, 0, 0, 16'h0000);
        send_request(CMD_COMPUTE, 0, 0, 63, 63, 16'h0000);

        // Random phases, each under its own shape. The sender pauses for a
        // full drain before every register write.
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: write_shape(7, 4, 4, 8, 64, 64, 0);          // largest shape
                1: write_shape(1, 1, 1, 1, 1, 1, 0);            // smallest shape
                2: write_shape(0, 0, 0, 0, 0, 0, 0);            // zeros clamp up to 1
                3: write_shape(127, 7, 6, 12, 100, 3, 127);     // over-range clamps down
                4: write_shape(7, 1, 2, 3, 3, 5, 0);            // kernel exceeds image
                5: write_shape(5, 2, 4, 8, 16, 16, 1);
                default: write_shape($urandom_range(1, 7), $urandom_range(1, 4),
                                     $urandom_range(1, 4), $urandom_range(1, 8),
                                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64)
                                                                 : $urandom_range(1, 12),
                                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64)
                                                                 : $urandom_range(1, 12),
                                     $urandom_range(0, 1));
            endcase
            steady = (phase == 5);
            random_phase(PHASE_ITEMS);
        end

        // Wind down: all results in, then a tail longer than any compute.
        start = 1'b0;
        while (sb.pending_sum.size() != 0) @(negedge i_clk);
        repeat (TAIL_TICKS) @(negedge i_clk);
        if (sb.pending_sum.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending_sum.size());
            sb.errors++;
        end

        $display("summary: %0d requests, %0d convolutions, %0d error statuses",
                 sb.requests, sb.convs, sb.bad_status);
        $display("summary: %0d register writes over %0d shapes, %0d mismatches",
                 sb.reg_writes, PHASES + 1, sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
